// File: sv/prq_pkg.sv
// Shared types and codes for the priority ready queue.
package prq_pkg;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_REPRIO = 2'd2;
	localparam logic [1:0] FUNC_YIELD  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BAD    = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	localparam logic [1:0] CELL_HOLD   = 2'd0;
	localparam logic [1:0] CELL_REMOVE = 2'd1;
	localparam logic [1:0] CELL_INSERT = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] task_id;
		logic [7:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [3:0] head_tid;
		logic       head_valid;
		logic [4:0] entry_count;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] tid;
	} cell_cmd_t;

endpackage

// File: sv/prq_cell.sv
// One queue slot: holds a task and its priority, shifts to or from its neighbors.
module prq_cell #(
	parameter int PB = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  prq_pkg::cell_cmd_t  cmd,
	input  logic [PB-1:0]       key_prio,
	input  logic                left_valid,
	input  logic [3:0]          left_tid,
	input  logic [PB-1:0]       left_prio,
	input  logic                left_gt,
	input  logic                right_valid,
	input  logic [3:0]          right_tid,
	input  logic [PB-1:0]       right_prio,
	input  logic                found_in,
	output logic                valid,
	output logic [3:0]          tid,
	output logic [PB-1:0]       prio,
	output logic                gt,
	output logic                found_out
);
	import prq_pkg::*;

	logic          valid_q;
	logic [3:0]    tid_q;
	logic [PB-1:0] prio_q;
	logic          match;

	assign match     = valid_q && (tid_q == cmd.tid);
	assign found_out = found_in | match;
	assign gt        = !(valid_q && (prio_q <= key_prio));
	assign valid     = valid_q;
	assign tid       = tid_q;
	assign prio      = prio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				CELL_REMOVE: begin
					if (found_out) begin
						valid_q <= right_valid;
					end
				end
				CELL_INSERT: begin
					if (left_gt) begin
						valid_q <= left_valid;
					end else if (gt) begin
						valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_REMOVE: begin
				if (found_out) begin
					tid_q  <= right_tid;
					prio_q <= right_prio;
				end
			end
			CELL_INSERT: begin
				if (left_gt) begin
					tid_q  <= left_tid;
					prio_q <= left_prio;
				end else if (gt) begin
					tid_q  <= cmd.tid;
					prio_q <= key_prio;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: sv/priority_ready_queue.sv
// Top level: sorted ready queue built from a row of slot cells plus a small sequencer.
// Sequence: a request beat passes through the remove state, the insert state when an entry
// is placed (insert, reprioritize, rotating yield) and the output state, which waits while the
// pending response is stalled. req_stall is high outside idle, so no new request is taken until
// the last response is registered; the cell row does a remove pass and then an insert pass.
// Reset: asynchronous, clears every slot's valid flag, the count and the handshake state.
// Payload registers are not reset.
module priority_ready_queue #(
	parameter int QUEUE_DEPTH   = 16,
	parameter int PRIORITY_BITS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  prq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output prq_pkg::rsp_t  rsp
);
	import prq_pkg::*;

	localparam int D  = QUEUE_DEPTH;
	localparam int PB = PRIORITY_BITS;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_REM  = 2'd1;
	localparam logic [1:0] S_INS  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]    state_q;
	logic [1:0]    func_q;
	logic [3:0]    tid_q;
	logic [PB-1:0] prio_q;
	logic [1:0]    status_q;
	logic [3:0]    ins_tid_q;
	logic [PB-1:0] ins_prio_q;
	logic [CW-1:0] count_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic [PB+7:0] prio_ext;
	logic [3:0]    key_tid;
	logic          prio_ok;
	logic          present;
	logic          do_remove;
	cell_cmd_t     cmd;

	logic [D-1:0]  c_valid;
	logic [3:0]    c_tid  [D];
	logic [PB-1:0] c_prio [D];
	logic [D-1:0]  c_gt;
	logic [D:0]    c_found;

	assign prio_ext  = (PB + 8)'(req.priority_req);
	assign key_tid   = (func_q == FUNC_YIELD) ? c_tid[0] : tid_q;
	assign prio_ok   = (prio_q != '0) && (prio_q != '1);
	assign present   = c_found[D];
	assign c_found[0] = 1'b0;

	always_comb begin
		do_remove = 1'b0;
		case (func_q)
			FUNC_REMOVE: do_remove = present;
			FUNC_REPRIO: do_remove = prio_ok && present;
			FUNC_YIELD:  do_remove = c_valid[0] && c_valid[1] && (c_prio[0] >= c_prio[1]);
			default:     do_remove = 1'b0;
		endcase
	end

	always_comb begin
		cmd.tid = key_tid;
		cmd.op  = CELL_HOLD;
		if (state_q == S_REM && do_remove) begin
			cmd.op = CELL_REMOVE;
		end else if (state_q == S_INS) begin
			cmd.op  = CELL_INSERT;
			cmd.tid = ins_tid_q;
		end
	end

	for (genvar i = 0; i < D; i++) begin : g_cell
		logic          l_valid;
		logic [3:0]    l_tid;
		logic [PB-1:0] l_prio;
		logic          l_gt;
		logic          r_valid;
		logic [3:0]    r_tid;
		logic [PB-1:0] r_prio;

		if (i == 0) begin : g_first
			assign l_valid = 1'b0;
			assign l_tid   = '0;
			assign l_prio  = '0;
			assign l_gt    = 1'b0;
		end else begin : g_mid
			assign l_valid = c_valid[i-1];
			assign l_tid   = c_tid[i-1];
			assign l_prio  = c_prio[i-1];
			assign l_gt    = c_gt[i-1];
		end

		if (i == D - 1) begin : g_last
			assign r_valid = 1'b0;
			assign r_tid   = '0;
			assign r_prio  = '0;
		end else begin : g_inner
			assign r_valid = c_valid[i+1];
			assign r_tid   = c_tid[i+1];
			assign r_prio  = c_prio[i+1];
		end

		prq_cell #(
			.PB(PB)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.key_prio   (ins_prio_q),
			.left_valid (l_valid),
			.left_tid   (l_tid),
			.left_prio  (l_prio),
			.left_gt    (l_gt),
			.right_valid(r_valid),
			.right_tid  (r_tid),
			.right_prio (r_prio),
			.found_in   (c_found[i]),
			.valid      (c_valid[i]),
			.tid        (c_tid[i]),
			.prio       (c_prio[i]),
			.gt         (c_gt[i]),
			.found_out  (c_found[i+1])
		);
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_REM;
					end
				end
				S_REM: begin
					if (do_remove) begin
						count_q <= count_q - 1'b1;
					end
					case (func_q)
						FUNC_INSERT: state_q <= (present || c_valid[D-1]) ? S_OUT : S_INS;
						FUNC_REMOVE: state_q <= S_OUT;
						default:     state_q <= do_remove ? S_INS : S_OUT;
					endcase
				end
				S_INS: begin
					count_q <= count_q + 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q <= req.func;
				tid_q  <= req.task_id;
				prio_q <= prio_ext[PB-1:0];
			end
			S_REM: begin
				ins_tid_q  <= key_tid;
				ins_prio_q <= (func_q == FUNC_YIELD) ? c_prio[0] : prio_q;
				status_q   <= ST_OK;
				case (func_q)
					FUNC_INSERT: begin
						if (present || c_valid[D-1]) begin
							status_q <= ST_FULL;
						end
					end
					FUNC_REMOVE: begin
						if (!present) begin
							status_q <= ST_ABSENT;
						end
					end
					FUNC_REPRIO: begin
						if (!prio_ok) begin
							status_q <= ST_BAD;
						end else if (!present) begin
							status_q <= ST_ABSENT;
						end
					end
					default: begin
						if (!c_valid[0]) begin
							status_q <= ST_ABSENT;
						end
					end
				endcase
			end
			S_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_q.head_tid    <= c_valid[0] ? c_tid[0] : 4'd0;
					rsp_q.head_valid  <= c_valid[0];
					rsp_q.entry_count <= 5'(count_q);
					rsp_q.status      <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
